// ----- rtl/core/depth_tested_pixel_blend_defines.svh -----
// Assertion macros shared by the pixel blend RTL.
// Used by dtpb_front and dtpb_back; expects clk and arst_n in scope.
`ifndef DEPTH_TESTED_PIXEL_BLEND_DEFINES_SVH
`define DEPTH_TESTED_PIXEL_BLEND_DEFINES_SVH

// same-cycle implication
`define DTPB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/dtpb_pkg.sv -----
// Package for the depth tested pixel blend: constants, codes, types, helpers.
// No dependencies.
package dtpb_pkg;

	localparam int unsigned COLOR_W    = 8;
	localparam int unsigned DEPTH_W    = 23;
	localparam int unsigned ZIN_W      = 24;
	localparam int unsigned RGB_W      = 3 * COLOR_W;
	localparam int unsigned OP_W       = 3;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned FRAME_W    = 9;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 23;
	localparam int unsigned QDEPTH     = 2;

	localparam logic [OP_W-1:0] OP_OPAQUE     = 3'd0;
	localparam logic [OP_W-1:0] OP_BLEND_Z    = 3'd1;
	localparam logic [OP_W-1:0] OP_BLEND_KEEP = 3'd2;
	localparam logic [OP_W-1:0] OP_READ       = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

	localparam logic [STATUS_W-1:0] ST_WRITTEN  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_DONE     = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_DEPTH    = 2'd2;

	localparam logic [FRAME_W-1:0] FRAME_RESET = 9'd256;
	localparam logic [DEPTH_W-1:0] FAR_RESET   = 23'd2000;
	localparam logic [COLOR_W-1:0] ALPHA_FULL  = 8'd255;

	typedef enum logic [2:0] {
		KIND_OPAQUE,
		KIND_BLEND_Z,
		KIND_BLEND_KEEP,
		KIND_READ,
		KIND_CLEAR,
		KIND_OUTSIDE
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               negative;
		logic [DEPTH_W-1:0] z;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] alpha;
	} work_t;

	typedef struct packed {
		logic  valid;
		work_t item;
	} head_t;

	typedef struct packed {
		logic accept_en;
		logic pop;
	} back_status_t;

	typedef enum logic [1:0] {
		BK_SWEEP,
		BK_IDLE,
		BK_READ,
		BK_CALC
	} back_state_t;

	// exact floor(sum / 255) for sum up to 255 * 255
	function automatic logic [COLOR_W-1:0] div255(input logic [2*COLOR_W-1:0] sum);
		logic [2*COLOR_W:0] t;
		t = {1'b0, sum} + 17'(sum[2*COLOR_W-1:COLOR_W]) + 17'd1;
		return t[2*COLOR_W-1:COLOR_W];
	endfunction

endpackage

// ----- rtl/core/dtpb_pixel_if.sv -----
// Pixel item channel: valid/ready handshake plus fragment payload.
// Depends on dtpb_pkg for field widths.
interface dtpb_pixel_if;
	import dtpb_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           opcode;
	logic [COLOR_W-1:0]        x_pos;
	logic [COLOR_W-1:0]        y_pos;
	logic signed [ZIN_W-1:0]   depth_value;
	logic [COLOR_W-1:0]        red;
	logic [COLOR_W-1:0]        green;
	logic [COLOR_W-1:0]        blue;
	logic [COLOR_W-1:0]        alpha;

	modport source (output valid, opcode, x_pos, y_pos, depth_value, red, green, blue, alpha,
		input ready);
	modport sink (input valid, opcode, x_pos, y_pos, depth_value, red, green, blue, alpha,
		output ready);
endinterface

// ----- rtl/core/dtpb_result_if.sv -----
// Result item channel: valid/ready handshake plus status and stored pixel.
// Depends on dtpb_pkg for field widths.
interface dtpb_result_if;
	import dtpb_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [COLOR_W-1:0]  read_red;
	logic [COLOR_W-1:0]  read_green;
	logic [COLOR_W-1:0]  read_blue;
	logic [DEPTH_W-1:0]  read_depth;

	modport source (output valid, status, read_red, read_green, read_blue, read_depth,
		input ready);
	modport sink (input valid, status, read_red, read_green, read_blue, read_depth,
		output ready);
endinterface

// ----- rtl/core/depth_tested_pixel_blend.sv -----
// Depth tested pixel blend: raster output stage with depth and RGB colour stores.
// Depends on dtpb_pkg, dtpb_pixel_if, dtpb_result_if, dtpb_ram, dtpb_front, dtpb_back.
// pixel_in carries one fragment item per handshake (valid and ready high at clk):
// opcode, x_pos, y_pos, depth_value, red, green, blue, alpha. result_out returns
// exactly one item per pixel item, in order: status and the stored pixel.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. Items
// queue in a two-entry buffer; the back end then takes one item at a time: an
// out-of-frame pixel is answered as it is taken, a read, reject or opaque write
// goes through a store read, a blended write through read, multiply and write,
// and a clear sweeps all MAX_WIDTH*MAX_HEIGHT entries. Each store has one write
// port and one read port. After reset all store entries (65536 by default) are
// swept with pixel_in.ready low; registers return to 256, 256 and 2000.
// A result waits in an output register while result_out.ready is low; the
// queue keeps taking items until it is full, then pixel_in.ready drops.
module depth_tested_pixel_blend #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	dtpb_pixel_if.sink                         pixel_in,
	dtpb_result_if.source                      result_out,
	input  logic                               cfg_we,
	input  logic [dtpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtpb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import dtpb_pkg::*;

	localparam int unsigned ENTRIES = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW      = $clog2(ENTRIES);

	logic [FRAME_W-1:0] frame_width_q;
	logic [FRAME_W-1:0] frame_height_q;
	logic [DEPTH_W-1:0] far_depth_q;

	head_t              head;
	logic [AW-1:0]      head_addr;
	back_status_t       back_st;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [DEPTH_W-1:0] depth_wdata;
	logic [RGB_W-1:0]   color_wdata;
	logic [DEPTH_W-1:0] depth_rdata;
	logic [RGB_W-1:0]   color_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_RESET;
			frame_height_q <= FRAME_RESET;
			far_depth_q    <= FAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[FRAME_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[FRAME_W-1:0];
				CFG_FAR_DEPTH:    far_depth_q    <= cfg_data[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	dtpb_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix          (pixel_in),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.back_st      (back_st),
		.head         (head),
		.head_addr    (head_addr)
	);

	dtpb_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_addr   (head_addr),
		.far_depth   (far_depth_q),
		.back_st     (back_st),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_raddr   (ram_raddr),
		.depth_wdata (depth_wdata),
		.color_wdata (color_wdata),
		.depth_rdata (depth_rdata),
		.color_rdata (color_rdata),
		.res         (result_out)
	);

	dtpb_ram #(
		.WIDTH (DEPTH_W),
		.DEPTH (ENTRIES)
	) u_depth_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (depth_wdata),
		.raddr (ram_raddr),
		.rdata (depth_rdata)
	);

	dtpb_ram #(
		.WIDTH (RGB_W),
		.DEPTH (ENTRIES)
	) u_color_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (color_wdata),
		.raddr (ram_raddr),
		.rdata (color_rdata)
	);
endmodule

// ----- rtl/core/dtpb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dtpb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/core/dtpb_front.sv -----
// Front end: accepts pixel items, classifies them, computes the store address
// and holds them in a two-entry queue. Depends on dtpb_pkg, dtpb_pixel_if, defines.
`include "depth_tested_pixel_blend_defines.svh"

module dtpb_front #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	dtpb_pixel_if.sink                                 pix,
	input  logic [dtpb_pkg::FRAME_W-1:0]               frame_width,
	input  logic [dtpb_pkg::FRAME_W-1:0]               frame_height,
	input  dtpb_pkg::back_status_t                     back_st,
	output dtpb_pkg::head_t                            head,
	output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]    head_addr
);
	import dtpb_pkg::*;

	localparam int unsigned AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int unsigned PW  = $clog2(QDEPTH);
	localparam int unsigned CW  = $clog2(QDEPTH + 1);

	work_t         cls;
	logic [AW-1:0] cls_addr;
	logic          outside;
	logic          push;
	logic          pop;

	work_t         item_q [QDEPTH];
	logic [AW-1:0] addr_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	always_comb begin
		outside = ({1'b0, pix.x_pos} >= frame_width) || (32'(pix.x_pos) >= MAX_WIDTH)
			|| ({1'b0, pix.y_pos} >= frame_height) || (32'(pix.y_pos) >= MAX_HEIGHT);
		cls.negative = pix.depth_value[ZIN_W-1];
		cls.z        = pix.depth_value[DEPTH_W-1:0];
		cls.red      = pix.red;
		cls.green    = pix.green;
		cls.blue     = pix.blue;
		cls.alpha    = pix.alpha;
		if (pix.opcode == OP_CLEAR) begin
			cls.kind = KIND_CLEAR;
		end else if (outside) begin
			cls.kind = KIND_OUTSIDE;
		end else begin
			case (pix.opcode)
				OP_OPAQUE:     cls.kind = KIND_OPAQUE;
				OP_BLEND_Z:    cls.kind = KIND_BLEND_Z;
				OP_BLEND_KEEP: cls.kind = (pix.alpha == ALPHA_FULL) ? KIND_BLEND_Z
					: KIND_BLEND_KEEP;
				OP_READ:       cls.kind = KIND_READ;
				default:       cls.kind = KIND_READ;
			endcase
		end
		cls_addr = AW'(32'(pix.y_pos) * MAX_WIDTH + 32'(pix.x_pos));
	end

	assign pix.ready = back_st.accept_en && (count_q != CW'(QDEPTH));
	assign push      = pix.valid && pix.ready;
	assign pop       = back_st.pop;

	always_ff @(posedge clk) begin
		if (push) begin
			item_q[wr_ptr_q] <= cls;
			addr_q[wr_ptr_q] <= cls_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = item_q[rd_ptr_q];
	assign head_addr  = addr_q[rd_ptr_q];

	`DTPB_ASSERT_NOW(a_pop_not_empty, pop, count_q != '0, "pop from empty queue")
	`DTPB_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(QDEPTH), "queue count overrun")
	`DTPB_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CW'(1),
		"queue count missed a push")
endmodule

// ----- rtl/core/dtpb_back.sv -----
// Back end: sweeps the stores, runs depth test, blend and store writes,
// and holds the result register. Depends on dtpb_pkg, dtpb_result_if, defines.
`include "depth_tested_pixel_blend_defines.svh"

module dtpb_back #(
	parameter int unsigned ENTRIES = 65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dtpb_pkg::head_t                   head,
	input  logic [$clog2(ENTRIES)-1:0]        head_addr,
	input  logic [dtpb_pkg::DEPTH_W-1:0]      far_depth,
	output dtpb_pkg::back_status_t            back_st,
	output logic                              ram_we,
	output logic [$clog2(ENTRIES)-1:0]        ram_waddr,
	output logic [$clog2(ENTRIES)-1:0]        ram_raddr,
	output logic [dtpb_pkg::DEPTH_W-1:0]      depth_wdata,
	output logic [dtpb_pkg::RGB_W-1:0]        color_wdata,
	input  logic [dtpb_pkg::DEPTH_W-1:0]      depth_rdata,
	input  logic [dtpb_pkg::RGB_W-1:0]        color_rdata,
	dtpb_result_if.source                     res
);
	import dtpb_pkg::*;

	localparam int unsigned AW = $clog2(ENTRIES);
	localparam int unsigned PW = 2 * COLOR_W;

	back_state_t        state_q, state_d;
	logic [AW-1:0]      sweep_cnt_q;
	logic               sweep_last;
	logic               report_q;
	logic               init_done_q;
	work_t              item_s1;
	logic [AW-1:0]      addr_s1;
	logic [PW-1:0]      new_r_s2, new_g_s2, new_b_s2;
	logic [PW-1:0]      old_r_s2, old_g_s2, old_b_s2;
	logic [DEPTH_W-1:0] old_depth_s2;
	logic [COLOR_W-1:0] inv_alpha;
	logic [RGB_W-1:0]   blended;
	logic [RGB_W-1:0]   new_rgb;

	logic               out_free;
	logic               take;
	logic               reject;
	logic               is_blend;
	logic               produce;
	logic [STATUS_W-1:0] prod_status;
	logic [RGB_W-1:0]   prod_rgb;
	logic [DEPTH_W-1:0] prod_depth;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [RGB_W-1:0]    out_rgb_q;
	logic [DEPTH_W-1:0]  out_depth_q;

	assign out_free   = !out_valid_q || res.ready;
	assign take       = (state_q == BK_IDLE) && head.valid && out_free;
	assign sweep_last = (sweep_cnt_q == AW'(ENTRIES - 1));
	assign reject     = item_s1.negative || (depth_rdata < item_s1.z);
	assign is_blend   = (item_s1.kind == KIND_BLEND_Z) || (item_s1.kind == KIND_BLEND_KEEP);
	assign inv_alpha  = ALPHA_FULL - item_s1.alpha;
	assign new_rgb    = {item_s1.red, item_s1.green, item_s1.blue};
	assign ram_raddr  = head_addr;

	assign blended = {div255(new_r_s2 + old_r_s2), div255(new_g_s2 + old_g_s2),
		div255(new_b_s2 + old_b_s2)};

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_SWEEP: begin
				if (sweep_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (take) begin
					case (head.item.kind)
						KIND_CLEAR:   state_d = BK_SWEEP;
						KIND_OUTSIDE: state_d = BK_IDLE;
						default:      state_d = BK_READ;
					endcase
				end
			end
			BK_READ: begin
				state_d = (is_blend && !reject) ? BK_CALC : BK_IDLE;
			end
			BK_CALC: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		back_st.accept_en = init_done_q;
		back_st.pop       = 1'b0;
		ram_we            = 1'b0;
		ram_waddr         = addr_s1;
		depth_wdata       = item_s1.z;
		color_wdata       = new_rgb;
		produce           = 1'b0;
		prod_status       = ST_DONE;
		prod_rgb          = color_rdata;
		prod_depth        = depth_rdata;
		case (state_q)
			BK_SWEEP: begin
				ram_we      = 1'b1;
				ram_waddr   = sweep_cnt_q;
				depth_wdata = far_depth;
				color_wdata = '0;
				if (sweep_last && report_q) begin
					produce     = 1'b1;
					prod_status = ST_DONE;
					prod_rgb    = '0;
					prod_depth  = far_depth;
				end
			end
			BK_IDLE: begin
				back_st.pop = take;
				if (take && head.item.kind == KIND_OUTSIDE) begin
					produce     = 1'b1;
					prod_status = ST_OUTSIDE;
					prod_rgb    = '0;
					prod_depth  = '0;
				end
			end
			BK_READ: begin
				if (item_s1.kind == KIND_READ) begin
					produce = 1'b1;
				end else if (reject) begin
					produce     = 1'b1;
					prod_status = ST_REJECTED;
				end else if (item_s1.kind == KIND_OPAQUE) begin
					ram_we      = 1'b1;
					produce     = 1'b1;
					prod_status = ST_WRITTEN;
					prod_rgb    = new_rgb;
					prod_depth  = item_s1.z;
				end
			end
			BK_CALC: begin
				ram_we      = 1'b1;
				color_wdata = blended;
				depth_wdata = (item_s1.kind == KIND_BLEND_Z) ? item_s1.z : old_depth_s2;
				produce     = 1'b1;
				prod_status = ST_WRITTEN;
				prod_rgb    = blended;
				prod_depth  = depth_wdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_SWEEP;
			sweep_cnt_q <= '0;
			report_q    <= 1'b0;
			init_done_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_SWEEP) begin
				sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + AW'(1);
				if (sweep_last) begin
					init_done_q <= 1'b1;
				end
			end
			if (take) begin
				report_q <= (head.item.kind == KIND_CLEAR);
			end
			if (produce) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= head.item;
			addr_s1 <= head_addr;
		end
		if (state_q == BK_READ) begin
			new_r_s2     <= PW'(item_s1.red) * PW'(item_s1.alpha);
			new_g_s2     <= PW'(item_s1.green) * PW'(item_s1.alpha);
			new_b_s2     <= PW'(item_s1.blue) * PW'(item_s1.alpha);
			old_r_s2     <= PW'(color_rdata[RGB_W-1 -: COLOR_W]) * PW'(inv_alpha);
			old_g_s2     <= PW'(color_rdata[COLOR_W +: COLOR_W]) * PW'(inv_alpha);
			old_b_s2     <= PW'(color_rdata[0 +: COLOR_W]) * PW'(inv_alpha);
			old_depth_s2 <= depth_rdata;
		end
		if (produce) begin
			out_status_q <= prod_status;
			out_rgb_q    <= prod_rgb;
			out_depth_q  <= prod_depth;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.status     = out_status_q;
	assign res.read_red   = out_rgb_q[RGB_W-1 -: COLOR_W];
	assign res.read_green = out_rgb_q[COLOR_W +: COLOR_W];
	assign res.read_blue  = out_rgb_q[0 +: COLOR_W];
	assign res.read_depth = out_depth_q;

	`DTPB_ASSERT_NOW(a_produce_free, produce, out_free, "result register overwritten")
	`DTPB_ASSERT_NOW(a_read_after_idle, state_q == BK_READ, $past(state_q) == BK_IDLE,
		"store data used without a read issued")
	`DTPB_ASSERT_NOW(a_no_pop_in_sweep, state_q == BK_SWEEP, !back_st.pop && ram_we,
		"item taken during store sweep")
endmodule
